/* design/ssidf_pkg.sv */
// Shared types, constants and helpers for the network-name display formatter.
// Used by every module of the block but ssidf_ram; depends on nothing.
`default_nettype none

package ssidf_pkg;

    localparam int COUNT_W = 6;
    localparam int CONT_W  = 2;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] ASCII_TOP  = 8'h80;

    localparam logic [7:0] QUOTE_CHAR = 8'h22;
    localparam logic [7:0] NULL_CHAR  = 8'h00;

    localparam logic [CONT_W-1:0] CONT_NONE  = 2'd0;
    localparam logic [CONT_W-1:0] CONT_ONE   = 2'd1;
    localparam logic [CONT_W-1:0] CONT_TWO   = 2'd2;
    localparam logic [CONT_W-1:0] CONT_THREE = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       has_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] char_value;
        logic       char_valid;
        logic       is_quoted_form;
        logic       truncated;
        logic       last_char;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic               malformed;
        logic               overflowed;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EMPTY,
        BK_OPEN,
        BK_TEXT,
        BK_CLOSE,
        BK_HEX_FETCH,
        BK_HEX_HI,
        BK_HEX_LO
    } back_state_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        logic [7:0] ch;
        if (nibble < 4'd10)
            ch = 8'h30 + {4'd0, nibble};
        else
            ch = 8'h57 + {4'd0, nibble};
        return ch;
    endfunction

endpackage

`default_nettype wire

/* design/ssidf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module ssidf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* design/ssidf_cmd_queue.sv */
// Short command queue between the front and back parts.
// Depends on ssidf_pkg for the command type and queue sizes.
`default_nettype none

module ssidf_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ssidf_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output ssidf_pkg::cmd_t     head,
    output logic                not_empty,
    output logic                full
);

    ssidf_pkg::cmd_t                     entry_reg [ssidf_pkg::QUEUE_DEPTH];
    logic [ssidf_pkg::QUEUE_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ssidf_pkg::QUEUE_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [ssidf_pkg::QUEUE_CW-1:0]      count_reg, count_next;
    logic                                do_push, do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == ssidf_pkg::QUEUE_CW'(ssidf_pkg::QUEUE_DEPTH));
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

/* design/ssidf_front.sv */
// Front part: accepts name bytes, writes them to the store, checks UTF-8
// structure and queues an emit command at the last byte. Depends on ssidf_pkg.
`default_nettype none

module ssidf_front #(
    parameter int MAX_NAME_BYTES = 32,
    parameter int AW             = 5
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire ssidf_pkg::item_t item,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [7:0]          wr_data,
    output logic                push,
    output ssidf_pkg::cmd_t     push_cmd
);

    logic [ssidf_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [ssidf_pkg::CONT_W-1:0]  cont_reg, cont_next;
    logic                          malformed_reg, malformed_next;
    logic                          overflowed_reg, overflowed_next;
    logic                          room;
    logic [7:0]                    b;

    assign b       = item.byte_value;
    assign room    = (count_reg < ssidf_pkg::COUNT_W'(MAX_NAME_BYTES));
    assign wr_en   = accept && item.has_byte && room;
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = b;

    always_comb
    begin
        count_next      = count_reg;
        cont_next       = cont_reg;
        malformed_next  = malformed_reg;
        overflowed_next = overflowed_reg;
        push            = 1'b0;
        push_cmd        = '0;

        if (accept && item.has_byte)
        begin
            if (!room)
                overflowed_next = 1'b1;
            else
            begin
                count_next = count_reg + 1'b1;
                if (cont_reg != ssidf_pkg::CONT_NONE)
                begin
                    if ((b & ssidf_pkg::CONT_MASK) == ssidf_pkg::CONT_CODE)
                        cont_next = cont_reg - 1'b1;
                    else
                    begin
                        malformed_next = 1'b1;
                        cont_next      = ssidf_pkg::CONT_NONE;
                    end
                end
                else if (b < ssidf_pkg::ASCII_TOP)
                    cont_next = ssidf_pkg::CONT_NONE;
                else if ((b & ssidf_pkg::LEAD2_MASK) == ssidf_pkg::LEAD2_CODE)
                    cont_next = ssidf_pkg::CONT_ONE;
                else if ((b & ssidf_pkg::LEAD3_MASK) == ssidf_pkg::LEAD3_CODE)
                    cont_next = ssidf_pkg::CONT_TWO;
                else if ((b & ssidf_pkg::LEAD4_MASK) == ssidf_pkg::LEAD4_CODE)
                    cont_next = ssidf_pkg::CONT_THREE;
                else
                    malformed_next = 1'b1;
            end
        end

        if (accept && item.last_byte)
        begin
            push                = 1'b1;
            push_cmd.byte_count = count_next;
            push_cmd.malformed  = malformed_next || (cont_next != ssidf_pkg::CONT_NONE);
            push_cmd.overflowed = overflowed_next;
            count_next          = '0;
            cont_next           = ssidf_pkg::CONT_NONE;
            malformed_next      = 1'b0;
            overflowed_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            cont_reg       <= ssidf_pkg::CONT_NONE;
            malformed_reg  <= 1'b0;
            overflowed_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            cont_reg       <= cont_next;
            malformed_reg  <= malformed_next;
            overflowed_reg <= overflowed_next;
        end
    end

endmodule

`default_nettype wire

/* design/ssidf_back.sv */
// Back part: takes emit commands from the queue, walks the store and drives
// the registered result port. Depends on ssidf_pkg.
`default_nettype none

module ssidf_back #(
    parameter int AW = 5
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ssidf_pkg::cmd_t head,
    input  wire logic           not_empty,
    output logic                pop,
    output logic                active,
    output logic [AW-1:0]       rd_addr,
    input  wire logic [7:0]     rd_data,
    output logic                strobe,
    output ssidf_pkg::result_t  result
);

    ssidf_pkg::back_state_t        state_reg, state_next;
    ssidf_pkg::cmd_t               cmd_reg, cmd_next;
    logic [ssidf_pkg::COUNT_W-1:0] idx_reg, idx_next;
    logic [7:0]                    byte_reg, byte_next;
    logic                          strobe_reg, strobe_next;
    ssidf_pkg::result_t            result_reg, result_next;
    logic                          at_end;

    assign active  = (state_reg != ssidf_pkg::BK_IDLE);
    assign rd_addr = idx_reg[AW-1:0];
    assign strobe  = strobe_reg;
    assign result  = result_reg;
    assign at_end  = (idx_reg == cmd_reg.byte_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ssidf_pkg::BK_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        byte_reg   <= byte_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        byte_next   = byte_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        pop         = 1'b0;

        result_next.truncated = cmd_reg.overflowed;

        unique case (state_reg)
            ssidf_pkg::BK_IDLE:
            begin
                if (not_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    idx_next = '0;
                    if (head.byte_count == '0)
                        state_next = ssidf_pkg::BK_EMPTY;
                    else if (!head.malformed)
                        state_next = ssidf_pkg::BK_OPEN;
                    else
                        state_next = ssidf_pkg::BK_HEX_FETCH;
                end
            end

            ssidf_pkg::BK_EMPTY:
            begin
                strobe_next                = 1'b1;
                result_next.char_value     = ssidf_pkg::NULL_CHAR;
                result_next.char_valid     = 1'b0;
                result_next.is_quoted_form = 1'b0;
                result_next.last_char      = 1'b1;
                state_next                 = ssidf_pkg::BK_IDLE;
            end

            ssidf_pkg::BK_OPEN:
            begin
                strobe_next                = 1'b1;
                result_next.char_value     = ssidf_pkg::QUOTE_CHAR;
                result_next.char_valid     = 1'b1;
                result_next.is_quoted_form = 1'b1;
                result_next.last_char      = 1'b0;
                idx_next                   = idx_reg + 1'b1;
                state_next                 = ssidf_pkg::BK_TEXT;
            end

            ssidf_pkg::BK_TEXT:
            begin
                strobe_next                = 1'b1;
                result_next.char_value     = rd_data;
                result_next.char_valid     = 1'b1;
                result_next.is_quoted_form = 1'b1;
                result_next.last_char      = 1'b0;
                if (at_end)
                    state_next = ssidf_pkg::BK_CLOSE;
                else
                    idx_next = idx_reg + 1'b1;
            end

            ssidf_pkg::BK_CLOSE:
            begin
                strobe_next                = 1'b1;
                result_next.char_value     = ssidf_pkg::QUOTE_CHAR;
                result_next.char_valid     = 1'b1;
                result_next.is_quoted_form = 1'b1;
                result_next.last_char      = 1'b1;
                state_next                 = ssidf_pkg::BK_IDLE;
            end

            ssidf_pkg::BK_HEX_FETCH:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = ssidf_pkg::BK_HEX_HI;
            end

            ssidf_pkg::BK_HEX_HI:
            begin
                strobe_next                = 1'b1;
                byte_next                  = rd_data;
                result_next.char_value     = ssidf_pkg::hex_char(rd_data[7:4]);
                result_next.char_valid     = 1'b1;
                result_next.is_quoted_form = 1'b0;
                result_next.last_char      = 1'b0;
                state_next                 = ssidf_pkg::BK_HEX_LO;
            end

            ssidf_pkg::BK_HEX_LO:
            begin
                strobe_next                = 1'b1;
                result_next.char_value     = ssidf_pkg::hex_char(byte_reg[3:0]);
                result_next.char_valid     = 1'b1;
                result_next.is_quoted_form = 1'b0;
                result_next.last_char      = at_end;
                if (at_end)
                    state_next = ssidf_pkg::BK_IDLE;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ssidf_pkg::BK_HEX_HI;
                end
            end

            default:
            begin
                state_next = ssidf_pkg::BK_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/ssidf_display_formatter_core.sv */
// Top level of the network-name display formatter: front, command queue,
// name store and back part. Depends on ssidf_pkg and all ssidf_* modules.
//
// Usage:
//   Drive item with start high; the item transfers at a rising edge where
//   start is high and busy is low. Bytes of a name transfer one per cycle
//   while busy stays low. The item with last_byte high closes the name.
//   From the cycle after that transfer, busy stays high up to the cycle that
//   carries the final result; no new item transfers meanwhile.
//   Results come out one per cycle on result, each marked by strobe for a
//   single cycle; the receiver must take every strobed result.
//   After the last item's transfer, its command passes through the queue,
//   the back part's open or empty state (its fetch and high-nibble states
//   for the hex form) and the result register. A quoted name of n bytes
//   gives n+2 results, a hex name 2n results, an empty name one result, all
//   in back-to-back cycles; the store's registered read port paces the walk.
//   Bytes beyond MAX_NAME_BYTES are dropped and flagged as truncated.
//   Reset clears the counters, the checker, the queue and the strobe; the
//   store contents stay undefined until written.
`default_nettype none

module ssid_display_formatter_core #(
    parameter int MAX_NAME_BYTES = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire ssidf_pkg::item_t item,
    output logic                strobe,
    output ssidf_pkg::result_t  result
);

    localparam int AW = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;

    logic              accept;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_data;
    logic              push;
    ssidf_pkg::cmd_t   push_cmd;
    logic              pop;
    ssidf_pkg::cmd_t   head;
    logic              not_empty;
    logic              full;
    logic              back_active;

    assign busy   = not_empty || full || back_active;
    assign accept = start && !busy;

    ssidf_front #(
        .MAX_NAME_BYTES (MAX_NAME_BYTES),
        .AW             (AW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ssidf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_NAME_BYTES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ssidf_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    ssidf_back #(
        .AW (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .active    (back_active),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .strobe    (strobe),
        .result    (result)
    );

endmodule

`default_nettype wire
